[rtl/csfe_pkg.sv]
// types, codes and size constants shared by the shape fill engine files
package csfe_pkg;

	localparam int CSFE_MAX_COLUMNS = 64;
	localparam int CSFE_MAX_ROWS    = 64;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

	localparam logic [6:0] CANVAS_WIDTH_RESET  = 7'd64;
	localparam logic [6:0] CANVAS_HEIGHT_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_SQUARE   = 2'd0,
		REQ_TRIANGLE = 2'd1,
		REQ_LINE     = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	localparam logic [1:0] STAT_ROW   = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_SLOPE = 2'd2;

	// how a column bound moves with the row distance from the anchor
	typedef enum logic [1:0] {
		COEF_NONE = 2'd0,
		COEF_ADD  = 2'd1,
		COEF_SUB  = 2'd2
	} coef_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] fill_size;
		logic [5:0] x_pos;
		logic [5:0] y_pos;
		logic [5:0] x_end;
		logic [5:0] y_end;
		logic       go_left;
		logic       go_up;
	} cmd_t;

	typedef struct packed {
		logic [63:0] row_bits;
		logic [5:0]  row_index;
		logic [1:0]  status;
		logic        last;
	} row_t;

endpackage

[rtl/canvas_shape_fill_engine_top.sv]
// shape fill engine: command decode, canvas row memory and row emitter
// Usage
// A command beat (cmd, cmd_valid, cmd_stall) fills a square, fills a right
// isosceles triangle or draws a line on a one-bit-per-pixel canvas held in
// a row memory of MAX_ROWS words of MAX_COLUMNS bits.
// A command whose checked corners leave the canvas in use, or a line that
// is not horizontal, vertical or diagonal, gives one rejected beat on the
// row channel (status set, last high). Otherwise every row in use goes out
// from row 0 upward, last high on the final row. Request code 3 is dropped.
// Each row is read from the memory, merged with the shape's pixels for that
// row, written back and put in the output register, one row per cycle while
// row_stall is low. cfg_we writes canvas_width (index 0) or canvas_height
// (index 1); the user must write them while idle; the block has no guard.
// cmd_stall stays high while a command is at work; the next command is taken
// the cycle after the last beat enters the output register.
// row_stall holds the output register and the read/merge stage behind it.
// Reset clears the per-row valid flags, so the canvas reads as empty, and
// sets both canvas size registers to 64; there is no clearing pass.
module canvas_shape_fill_engine_top #(
	parameter int MAX_COLUMNS = csfe_pkg::CSFE_MAX_COLUMNS,
	parameter int MAX_ROWS    = csfe_pkg::CSFE_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csfe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  csfe_pkg::cmd_t                 cmd,
	output logic                           row_valid,
	input  logic                           row_stall,
	output csfe_pkg::row_t                 row
);

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_REJ   = 4'b1000
	} state_t;

	state_t state_q;

	logic [6:0] width_q, height_q;
	logic [6:0] cols_eff, rows_eff;

	// command decode
	logic              cmd_acc;
	logic signed [8:0] x9, y9, x2_9, y2_9, w9, cols9, rows9;
	logic signed [8:0] far_x, far_y, dx, dy, adx, ady;
	logic              anchor_ok, far_ok;
	logic [1:0]        status_d;
	logic signed [8:0] row_lo_d, row_hi_d, base_lo_d, base_hi_d;
	csfe_pkg::coef_t   coef_lo_d, coef_hi_d;

	logic [1:0]        status_q;
	logic signed [8:0] row_lo_q, row_hi_q, base_lo_q, base_hi_q;
	csfe_pkg::coef_t   coef_lo_q, coef_hi_q;
	logic signed [8:0] y_q;

	// row pipeline
	logic [ROW_W-1:0]       rd_row_q;
	logic                   rd_go, rd_last;
	logic                   s1_valid_q;
	logic [ROW_W-1:0]       row_s1;
	logic                   last_s1;
	logic [MAX_COLUMNS-1:0] data_s1;
	logic                   hit_s1_valid;
	logic                   s1_adv, out_free, load_rej;

	logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
	logic [MAX_ROWS-1:0]    row_valid_q;

	logic signed [8:0]      r9, diff, row_dist, col_lo, col_hi;
	logic                   row_hit;
	logic [63:0]            shape_mask, col_mask;
	logic [MAX_COLUMNS-1:0] merged;

	logic           out_valid_q;
	csfe_pkg::row_t out_q;

	assign cols_eff = (width_q > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : width_q;
	assign rows_eff = (height_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : height_q;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= csfe_pkg::CANVAS_WIDTH_RESET;
			height_q <= csfe_pkg::CANVAS_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csfe_pkg::REG_CANVAS_WIDTH:  width_q  <= cfg_data;
				csfe_pkg::REG_CANVAS_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// corner checks and per-command row and column bounds
	always_comb begin
		x9    = signed'(9'(cmd.x_pos));
		y9    = signed'(9'(cmd.y_pos));
		x2_9  = signed'(9'(cmd.x_end));
		y2_9  = signed'(9'(cmd.y_end));
		w9    = signed'(9'(cmd.fill_size));
		cols9 = signed'(9'(cols_eff));
		rows9 = signed'(9'(rows_eff));
		dx    = x2_9 - x9;
		dy    = y2_9 - y9;
		adx   = (dx < 0) ? -dx : dx;
		ady   = (dy < 0) ? -dy : dy;

		far_x     = x2_9;
		far_y     = y2_9;
		row_lo_d  = y9;
		row_hi_d  = y9 + w9 - 9'sd1;
		base_lo_d = x9;
		base_hi_d = x9 + w9 - 9'sd1;
		coef_lo_d = csfe_pkg::COEF_NONE;
		coef_hi_d = csfe_pkg::COEF_NONE;

		case (cmd.req_type)
			csfe_pkg::REQ_SQUARE: begin
				far_x = x9 + w9 - 9'sd1;
				far_y = y9 + w9 - 9'sd1;
			end
			csfe_pkg::REQ_TRIANGLE: begin
				far_x = cmd.go_left ? (x9 - w9 + 9'sd1) : (x9 + w9 - 9'sd1);
				far_y = cmd.go_up ? (y9 - w9 + 9'sd1) : (y9 + w9 - 9'sd1);
				if (cmd.go_up) begin
					row_lo_d = y9 - w9 + 9'sd1;
					row_hi_d = y9;
				end
				// a row at distance d from the anchor spans w-d columns
				if (cmd.go_left) begin
					base_lo_d = x9 - w9 + 9'sd1;
					base_hi_d = x9;
					coef_lo_d = csfe_pkg::COEF_ADD;
				end else begin
					coef_hi_d = csfe_pkg::COEF_SUB;
				end
			end
			csfe_pkg::REQ_LINE: begin
				row_lo_d = (y2_9 < y9) ? y2_9 : y9;
				row_hi_d = (y2_9 < y9) ? y9 : y2_9;
				if (dy == 9'sd0) begin
					base_lo_d = (x2_9 < x9) ? x2_9 : x9;
					base_hi_d = (x2_9 < x9) ? x9 : x2_9;
				end else begin
					base_lo_d = x9;
					base_hi_d = x9;
					if (dx > 9'sd0) begin
						coef_lo_d = csfe_pkg::COEF_ADD;
						coef_hi_d = csfe_pkg::COEF_ADD;
					end else if (dx < 9'sd0) begin
						coef_lo_d = csfe_pkg::COEF_SUB;
						coef_hi_d = csfe_pkg::COEF_SUB;
					end
				end
			end
			default: ;
		endcase

		anchor_ok = (x9 < cols9) && (y9 < rows9);
		far_ok    = (far_x >= 9'sd0) && (far_y >= 9'sd0) && (far_x < cols9) && (far_y < rows9);

		if (!anchor_ok || !far_ok)
			status_d = csfe_pkg::STAT_RANGE;
		else if (cmd.req_type == csfe_pkg::REQ_LINE && dx != 9'sd0 && dy != 9'sd0
				&& adx != ady)
			status_d = csfe_pkg::STAT_SLOPE;
		else
			status_d = csfe_pkg::STAT_ROW;
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			status_q  <= status_d;
			row_lo_q  <= row_lo_d;
			row_hi_q  <= row_hi_d;
			base_lo_q <= base_lo_d;
			base_hi_q <= base_hi_d;
			coef_lo_q <= coef_lo_d;
			coef_hi_q <= coef_hi_d;
			y_q       <= signed'(9'(cmd.y_pos));
		end
	end

	// handshake of the row pipeline
	assign out_free = !out_valid_q || !row_stall;
	assign s1_adv   = s1_valid_q && out_free;
	assign load_rej = (state_q == ST_REJ) && out_free;
	assign rd_go    = (state_q == ST_RUN) && (!s1_valid_q || s1_adv);
	assign rd_last  = (7'(rd_row_q) == rows_eff - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_row_q   <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (rd_go)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					rd_row_q <= '0;
					if (cmd_acc && cmd.req_type != csfe_pkg::REQ_NONE) begin
						if (status_d != csfe_pkg::STAT_ROW)
							state_q <= ST_REJ;
						else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rd_go) begin
						rd_row_q <= rd_row_q + 1'b1;
						if (rd_last)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (s1_adv && last_s1)
						state_q <= ST_IDLE;
				end
				ST_REJ: begin
					if (load_rej)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// canvas memory: read one row, write it back merged as stage 1 advances
	always_ff @(posedge clk) begin
		if (rd_go) begin
			data_s1      <= mem[rd_row_q];
			hit_s1_valid <= row_valid_q[rd_row_q];
			row_s1       <= rd_row_q;
			last_s1      <= rd_last;
		end
		if (s1_adv)
			mem[row_s1] <= merged;
	end

	// rows never written read as cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (s1_adv)
			row_valid_q[row_s1] <= 1'b1;
	end

	// pixels of the shape in the row held in stage 1
	always_comb begin
		r9       = signed'(9'(row_s1));
		diff     = r9 - y_q;
		row_dist = (diff < 0) ? -diff : diff;
		row_hit  = (r9 >= row_lo_q) && (r9 <= row_hi_q);

		case (coef_lo_q)
			csfe_pkg::COEF_ADD: col_lo = base_lo_q + row_dist;
			csfe_pkg::COEF_SUB: col_lo = base_lo_q - row_dist;
			default:            col_lo = base_lo_q;
		endcase
		case (coef_hi_q)
			csfe_pkg::COEF_ADD: col_hi = base_hi_q + row_dist;
			csfe_pkg::COEF_SUB: col_hi = base_hi_q - row_dist;
			default:            col_hi = base_hi_q;
		endcase

		for (int i = 0; i < 64; i++) begin
			shape_mask[i] = row_hit && (9'(i) >= 9'(col_lo)) && (signed'(9'(i)) <= col_hi)
				&& (col_lo >= 9'sd0);
			col_mask[i]   = (7'(i) < cols_eff);
		end

		merged = (hit_s1_valid ? data_s1 : '0) | shape_mask[MAX_COLUMNS-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_rej || s1_adv)
			out_valid_q <= 1'b1;
		else if (!row_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_rej) begin
			out_q.row_bits  <= '0;
			out_q.row_index <= '0;
			out_q.status    <= status_q;
			out_q.last      <= 1'b1;
		end else if (s1_adv) begin
			out_q.row_bits  <= 64'(merged) & col_mask;
			out_q.row_index <= 6'(row_s1);
			out_q.status    <= csfe_pkg::STAT_ROW;
			out_q.last      <= last_s1;
		end
	end

	assign row_valid = out_valid_q;
	assign row       = out_q;

endmodule

[rtl/csfe_checker.sv]
// port-level checks of the shape fill engine and their binding
module csfe_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input csfe_pkg::cmd_t cmd,
	input logic           row_valid,
	input logic           row_stall,
	input csfe_pkg::row_t row
);

	// a stalled result beat holds
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_stall |=> row_valid && $stable(row))
		else $error("row beat changed while stalled");

	// a rejection is a single empty beat for row 0
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row.status != csfe_pkg::STAT_ROW |->
			row.last && row.row_bits == 64'd0 && row.row_index == 6'd0)
		else $error("rejected beat is not a lone empty beat");

	// a real command, once taken, makes the block go busy
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.req_type != csfe_pkg::REQ_NONE |=> cmd_stall)
		else $error("command taken without going busy");

	// a beat that directly follows an accepted final beat is row 0
	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && row.last |=>
			!row_valid || row.row_index == 6'd0)
		else $error("beat after a final beat is not row 0");

endmodule

bind canvas_shape_fill_engine_top csfe_checker u_csfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.row_valid (row_valid),
	.row_stall (row_stall),
	.row       (row)
);
